// ----- rtl/qau_pkg.sv -----
// ----------------------------------------------------------------------------
// qau_pkg
// Operation and status codes shared by the quaternion arithmetic unit.
// ----------------------------------------------------------------------------
package qau_pkg;

  // operation codes (input tuser)
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;  // Hamilton product a*b
  localparam logic [2:0] OP_SCL = 3'd3;  // a * scalar
  localparam logic [2:0] OP_DIV = 3'd4;  // a / scalar
  localparam logic [2:0] OP_CNJ = 3'd5;  // conjugate of a
  localparam logic [2:0] OP_INV = 3'd6;  // conj(a) / |a|^2
  localparam logic [2:0] OP_NOP = 3'd7;  // unused, zero result

  // status codes (output tuser)
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DZ  = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

endpackage

// ----- rtl/quaternion_arithmetic_unit.sv -----
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit
// Fixed-point quaternion ALU: add, sub, Hamilton product, scale, divide,
// conjugate and inverse, saturated results with status.
// ----------------------------------------------------------------------------
// The unit takes one word per cycle while the output is not stalled and
// returns one result word per input word, in order. The pipeline depth is
// set by the restoring divider, one quotient bit per stage over a
// WORD_BITS + 2*FRAC_BITS bit numerator (64 bits at the default Q16.16);
// every opcode runs the full pipeline so results never reorder. A stall on
// the output freezes the whole pipeline.
module quaternion_arithmetic_unit
  import qau_pkg::*;
#(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, scalar
  input  logic [((9*WORD_BITS+7)/8)*8-1:0]       in_tdata,
  // func
  input  logic [2:0]                             in_tuser,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // r_w, r_x, r_y, r_z
  output logic [((4*WORD_BITS+7)/8)*8-1:0]       out_tdata,
  // status
  output logic [1:0]                             out_tuser
);

  localparam int W    = WORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int PW   = 2*W;              // product width
  localparam int VW   = 2*W + 2;          // sum of four products
  localparam int NUMW = W + 2*F;          // divider numerator width
  localparam int DENW = 2*W + 1;          // divisor width (norm squared)
  localparam int FW   = (VW > NUMW + 1) ? VW : NUMW + 1;
  localparam int OTW  = ((4*W+7)/8)*8;

  typedef struct packed {
    logic                      vld;
    logic [2:0]                fn;
    logic                      dz;
    logic [3:0]                qneg;
    logic [3:0][VW-1:0]        pre;
    logic [DENW-1:0]           den;
    logic [3:0][DENW-1:0]      rem;
    logic [3:0][NUMW-1:0]      nq;
  } dstg_t;

  logic en;

  // whole pipeline advances unless the output word is held
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // --------------------------------------------------------------------------
  // Stage 1: sixteen multipliers
  // --------------------------------------------------------------------------
  logic signed [W-1:0]  ia [4];
  logic signed [W-1:0]  ib [4];
  logic signed [W-1:0]  is_s;
  logic signed [W-1:0]  ml [16];
  logic signed [W-1:0]  mr [16];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      ia[c] = in_tdata[c*W +: W];
      ib[c] = in_tdata[(4+c)*W +: W];
    end
    is_s = in_tdata[8*W +: W];
    // first product of each row is shared by product, scale and norm
    for (int c = 0; c < 4; c++) begin
      ml[4*c] = (in_tuser == OP_MUL) ? ia[0] : ia[c];
      mr[4*c] = (in_tuser == OP_MUL) ? ib[c] : ((in_tuser == OP_SCL) ? is_s : ia[c]);
    end
    ml[1]  = ia[1]; mr[1]  = ib[1];
    ml[2]  = ia[2]; mr[2]  = ib[2];
    ml[3]  = ia[3]; mr[3]  = ib[3];
    ml[5]  = ib[0]; mr[5]  = ia[1];
    ml[6]  = ia[2]; mr[6]  = ib[3];
    ml[7]  = ia[3]; mr[7]  = ib[2];
    ml[9]  = ib[0]; mr[9]  = ia[2];
    ml[10] = ia[3]; mr[10] = ib[1];
    ml[11] = ia[1]; mr[11] = ib[3];
    ml[13] = ib[0]; mr[13] = ia[3];
    ml[14] = ia[1]; mr[14] = ib[2];
    ml[15] = ia[2]; mr[15] = ib[1];
  end

  logic                 v1_r;
  logic [2:0]           fn1_r;
  logic signed [W-1:0]  a1_r [4];
  logic signed [W-1:0]  b1_r [4];
  logic signed [W-1:0]  s1_r;
  logic signed [PW-1:0] pp1_r [16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fn1_r <= in_tuser;
      s1_r  <= is_s;
      for (int c = 0; c < 4; c++) begin
        a1_r[c] <= ia[c];
        b1_r[c] <= ib[c];
      end
      for (int k = 0; k < 16; k++) begin
        pp1_r[k] <= PW'(ml[k]) * PW'(mr[k]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: product sums and norm
  // --------------------------------------------------------------------------
  logic signed [VW-1:0] px [16];
  logic signed [VW-1:0] sum2 [4];
  logic signed [VW-1:0] nrm2;

  always_comb begin
    for (int k = 0; k < 16; k++) begin
      px[k] = VW'(pp1_r[k]);
    end
    if (fn1_r == OP_MUL) begin
      sum2[0] = px[0]  - px[1]  - px[2]  - px[3];
      sum2[1] = px[4]  + px[5]  + px[6]  - px[7];
      sum2[2] = px[8]  + px[9]  + px[10] - px[11];
      sum2[3] = px[12] + px[13] + px[14] - px[15];
    end else begin
      for (int c = 0; c < 4; c++) begin
        sum2[c] = px[4*c];
      end
    end
    nrm2 = px[0] + px[4] + px[8] + px[12];
  end

  logic                 v2_r;
  logic [2:0]           fn2_r;
  logic signed [W-1:0]  a2_r [4];
  logic signed [W-1:0]  b2_r [4];
  logic signed [W-1:0]  s2_r;
  logic signed [VW-1:0] sum2_r [4];
  logic signed [VW-1:0] n2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fn2_r <= fn1_r;
      s2_r  <= s1_r;
      n2_r  <= nrm2;
      for (int c = 0; c < 4; c++) begin
        a2_r[c]   <= a1_r[c];
        b2_r[c]   <= b1_r[c];
        sum2_r[c] <= sum2[c];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: direct results and divider operands
  // --------------------------------------------------------------------------
  dstg_t dst_r [NUMW+1];
  dstg_t d3;

  always_comb begin
    logic signed [W:0] sx;
    logic        [W:0] smag;
    logic signed [W:0] ax;
    logic        [W:0] amag;
    logic signed [VW-1:0] ae;
    d3     = '0;
    d3.vld = v2_r;
    d3.fn  = fn2_r;
    sx     = {s2_r[W-1], s2_r};
    smag   = (sx < 0) ? unsigned'(-sx) : unsigned'(sx);
    d3.dz  = ((fn2_r == OP_DIV) && (s2_r == '0)) || ((fn2_r == OP_INV) && (n2_r == '0));
    for (int c = 0; c < 4; c++) begin
      ax   = {a2_r[c][W-1], a2_r[c]};
      amag = (ax < 0) ? unsigned'(-ax) : unsigned'(ax);
      ae   = VW'(a2_r[c]);
      unique case (fn2_r)
        OP_ADD: d3.pre[c] = ae + VW'(b2_r[c]);
        OP_SUB: d3.pre[c] = ae - VW'(b2_r[c]);
        OP_MUL,
        OP_SCL: d3.pre[c] = sum2_r[c] >>> F;
        OP_CNJ: d3.pre[c] = (c == 0) ? ae : -ae;
        OP_DIV: begin
          d3.nq[c]   = NUMW'(amag) << F;
          d3.qneg[c] = a2_r[c][W-1] ^ s2_r[W-1];
        end
        OP_INV: begin
          d3.nq[c]   = NUMW'(amag) << (2*F);
          d3.qneg[c] = (c == 0) ? a2_r[c][W-1] : !a2_r[c][W-1];
        end
        default: d3.pre[c] = '0;
      endcase
    end
    if (fn2_r == OP_DIV) begin
      d3.den = DENW'(smag);
    end else if (fn2_r == OP_INV) begin
      d3.den = n2_r[DENW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dst_r[0].vld <= 1'b0;
    end else if (en) begin
      dst_r[0] <= d3;
    end
  end

  // --------------------------------------------------------------------------
  // Restoring divider, one quotient bit per stage, four lanes
  // --------------------------------------------------------------------------
  for (genvar k = 0; k < NUMW; k++) begin : g_div
    dstg_t dn;

    always_comb begin
      logic [DENW:0] t;
      logic          ge;
      dn = dst_r[k];
      for (int c = 0; c < 4; c++) begin
        t  = {dst_r[k].rem[c], dst_r[k].nq[c][NUMW-1]};
        ge = (t >= {1'b0, dst_r[k].den});
        dn.rem[c] = ge ? DENW'(t - {1'b0, dst_r[k].den}) : t[DENW-1:0];
        dn.nq[c]  = {dst_r[k].nq[c][NUMW-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dst_r[k+1].vld <= 1'b0;
      end else if (en) begin
        dst_r[k+1] <= dn;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: select, saturate, status
  // --------------------------------------------------------------------------
  localparam logic signed [FW-1:0] MAXV = FW'({1'b0, {(W-1){1'b1}}});
  localparam logic signed [FW-1:0] MINV = -MAXV - FW'(1);

  logic [W-1:0] rv_nxt [4];
  logic [1:0]   st_nxt;

  always_comb begin
    logic signed [FW-1:0] x;
    logic signed [FW-1:0] q;
    logic                 sat;
    logic                 isdiv;
    sat   = 1'b0;
    isdiv = (dst_r[NUMW].fn == OP_DIV) || (dst_r[NUMW].fn == OP_INV);
    for (int c = 0; c < 4; c++) begin
      q = FW'(dst_r[NUMW].nq[c]);
      if (isdiv) begin
        x = dst_r[NUMW].qneg[c] ? -q : q;
      end else begin
        x = FW'($signed(dst_r[NUMW].pre[c]));
      end
      if (dst_r[NUMW].dz) begin
        rv_nxt[c] = '0;
      end else if (x > MAXV) begin
        rv_nxt[c] = MAXV[W-1:0];
        sat       = 1'b1;
      end else if (x < MINV) begin
        rv_nxt[c] = MINV[W-1:0];
        sat       = 1'b1;
      end else begin
        rv_nxt[c] = x[W-1:0];
      end
    end
    if (dst_r[NUMW].dz) begin
      st_nxt = ST_DZ;
    end else if (sat) begin
      st_nxt = ST_SAT;
    end else begin
      st_nxt = ST_OK;
    end
  end

  logic         vo_r;
  logic [2:0]   fno_r;
  logic [W-1:0] rv_r [4];
  logic [1:0]   st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= dst_r[NUMW].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fno_r <= dst_r[NUMW].fn;
      st_r  <= st_nxt;
      for (int c = 0; c < 4; c++) begin
        rv_r[c] <= rv_nxt[c];
      end
    end
  end

  assign out_tvalid = vo_r;
  assign out_tdata  = OTW'({rv_r[3], rv_r[2], rv_r[1], rv_r[0]});
  assign out_tuser  = st_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // divide-by-zero status only from divide or inverse
  a_dz_op: assert property (@(posedge clk) disable iff (!rst_n)
    (vo_r && st_r == ST_DZ) |-> (fno_r == OP_DIV || fno_r == OP_INV))
    else $error("divide-by-zero status on a non-dividing op");

  // divide-by-zero result is all zeros
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (vo_r && st_r == ST_DZ) |-> (rv_r[0] == '0 && rv_r[1] == '0 &&
                                 rv_r[2] == '0 && rv_r[3] == '0))
    else $error("divide-by-zero word carries nonzero data");

  // saturated status means some component sits on a bound
  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (vo_r && st_r == ST_SAT) |->
      (rv_r[0] == MAXV[W-1:0] || rv_r[0] == MINV[W-1:0] ||
       rv_r[1] == MAXV[W-1:0] || rv_r[1] == MINV[W-1:0] ||
       rv_r[2] == MAXV[W-1:0] || rv_r[2] == MINV[W-1:0] ||
       rv_r[3] == MAXV[W-1:0] || rv_r[3] == MINV[W-1:0]))
    else $error("saturation flagged with no clamped component");

  // unused opcode yields an ok word; the w and z components are checked for zero
  a_unused_op: assert property (@(posedge clk) disable iff (!rst_n)
    (vo_r && fno_r == OP_NOP) |-> (st_r == ST_OK && rv_r[0] == '0 && rv_r[3] == '0))
    else $error("unused opcode gave a nonzero result");

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Stream-level check of the quaternion arithmetic unit. A directed table
// covers extremes, every opcode, zero divisors and saturation; random
// operations follow. Each result word is checked, in order, against a
// table entry or in-bench fixed-point predictor; random stalls both sides.
// ----------------------------------------------------------------------------
module tb_top;
  import qau_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = 16;
  localparam int NRAND = 1600;
  localparam logic signed [31:0] QMAX = 32'sh7fffffff;
  localparam logic signed [31:0] QMIN = 32'sh80000000;
  localparam logic signed [31:0] ONE  = 32'sh00010000;

  typedef struct {
    logic [2:0]        func;
    logic signed [31:0] a [4];
    logic signed [31:0] b [4];
    logic signed [31:0] s;
  } op_word_t;

  typedef struct {
    logic signed [31:0] r [4];
    logic [1:0]         st;
  } res_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [287:0] in_tdata = '0;
  logic [2:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [127:0] out_tdata;
  logic [1:0] out_tuser;

  res_word_t quat_expq[$];
  int errors = 0;
  int out_hold = 0;

  quaternion_arithmetic_unit u_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // saturate a wide value into one Q16.16 component
  function automatic logic signed [31:0] clamp(input logic signed [255:0] v,
                                              inout logic sat);
    if (v > 256'(QMAX)) begin sat = 1'b1; return QMAX; end
    if (v < 256'(QMIN) || v < -256'sd2147483648) begin
      sat = 1'b1; return QMIN;
    end
    return v[31:0];
  endfunction

  // truncating signed divide on wide values
  function automatic logic signed [255:0] sdiv(input logic signed [255:0] n,
                                              input logic signed [255:0] d);
    logic [255:0] un, ud, q;
    un = n[255] ? -n : n;
    ud = d[255] ? -d : d;
    q = un / ud;
    return (n[255] != d[255]) ? -q : q;
  endfunction

  function automatic res_word_t quat_result(input op_word_t w);
    res_word_t o;
    logic signed [255:0] a [4], b [4], r [4], s, n;
    logic sat, dz;
    sat = 1'b0; dz = 1'b0;
    for (int i = 0; i < 4; i++) begin
      a[i] = w.a[i]; b[i] = w.b[i]; r[i] = '0;
    end
    s = w.s;
    case (w.func)
      OP_ADD: for (int i = 0; i < 4; i++) r[i] = a[i] + b[i];
      OP_SUB: for (int i = 0; i < 4; i++) r[i] = a[i] - b[i];
      OP_MUL: begin
        r[0] = (a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3]) >>> FB;
        r[1] = (a[0]*b[1] + b[0]*a[1] + a[2]*b[3] - a[3]*b[2]) >>> FB;
        r[2] = (a[0]*b[2] + b[0]*a[2] + a[3]*b[1] - a[1]*b[3]) >>> FB;
        r[3] = (a[0]*b[3] + b[0]*a[3] + a[1]*b[2] - a[2]*b[1]) >>> FB;
      end
      OP_SCL: for (int i = 0; i < 4; i++) r[i] = (a[i] * s) >>> FB;
      OP_DIV: begin
        if (s == 0) dz = 1'b1;
        else for (int i = 0; i < 4; i++) r[i] = sdiv(a[i] <<< FB, s);
      end
      OP_CNJ: begin
        r[0] = a[0];
        for (int i = 1; i < 4; i++) r[i] = -a[i];
      end
      OP_INV: begin
        n = a[0]*a[0] + a[1]*a[1] + a[2]*a[2] + a[3]*a[3];
        if (n == 0) dz = 1'b1;
        else for (int i = 0; i < 4; i++)
          r[i] = sdiv((i == 0 ? a[0] : -a[i]) <<< (2*FB), n);
      end
      default: ;
    endcase
    for (int i = 0; i < 4; i++) o.r[i] = clamp(r[i], sat);
    o.st = dz ? ST_DZ : (sat ? ST_SAT : ST_OK);
    return o;
  endfunction

  // directed table
  op_word_t dir_tbl[$];
  res_word_t dir_exp[$];
  bit dir_has_exp[$];

  function automatic op_word_t mk(input logic [2:0] f,
      input logic signed [31:0] aw, ax, ay, az, bw, bx, by, bz, sc);
    op_word_t w;
    w.func = f;
    w.a[0] = aw; w.a[1] = ax; w.a[2] = ay; w.a[3] = az;
    w.b[0] = bw; w.b[1] = bx; w.b[2] = by; w.b[3] = bz;
    w.s = sc;
    return w;
  endfunction

  function automatic res_word_t mkr(input logic signed [31:0] w0, w1, w2, w3,
                                    input logic [1:0] st);
    res_word_t o;
    o.r[0] = w0; o.r[1] = w1; o.r[2] = w2; o.r[3] = w3; o.st = st;
    return o;
  endfunction

  task automatic add_row(input op_word_t w, input bit has, input res_word_t e);
    dir_tbl.push_back(w); dir_has_exp.push_back(has); dir_exp.push_back(e);
  endtask

  function automatic logic signed [31:0] rnd_comp(input int mode);
    case (mode)
      0: return $urandom;
      1: return $urandom_range(0, 4) == 0 ? QMAX : ($urandom_range(0, 1) ? QMIN : 0);
      default: return $signed(32'($urandom_range(0, 32'h3ffff))) - 32'sh20000;
    endcase
  endfunction

  function automatic op_word_t rnd_word();
    op_word_t w;
    int mode;
    mode = $urandom_range(0, 9) < 2 ? $urandom_range(0, 1) : 2;
    w.func = $urandom_range(0, 15) == 0 ? OP_NOP : 3'($urandom_range(0, 6));
    for (int i = 0; i < 4; i++) begin
      w.a[i] = rnd_comp(mode); w.b[i] = rnd_comp(mode);
    end
    w.s = $urandom_range(0, 19) == 0 ? 32'sd0 : rnd_comp(mode);
    if (w.func == OP_INV && $urandom_range(0, 9) == 0)
      for (int i = 0; i < 4; i++) w.a[i] = 0;
    return w;
  endfunction

  function automatic int gap_len();
    return $urandom_range(0, 19) == 0 ? $urandom_range(5, 40)
         : ($urandom_range(0, 2) == 0 ? $urandom_range(0, 3) : 0);
  endfunction

  // send one word and queue its prediction; valid drops only for a gap
  task automatic send_word(input op_word_t w, input bit has, input res_word_t e);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= w.func;
    in_tdata  <= {w.s, w.b[3], w.b[2], w.b[1], w.b[0],
                  w.a[3], w.a[2], w.a[1], w.a[0]};
    do @(posedge clk); while (!in_tready);
    quat_expq.push_back(has ? e : quat_result(w));
  endtask

  // result side: random stalls and in-order compare
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      res_word_t e;
      logic [127:0] ed;
      if (quat_expq.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %h/%0d", out_tdata, out_tuser);
      end else begin
        e = quat_expq.pop_front();
        ed = {e.r[3], e.r[2], e.r[1], e.r[0]};
        if (ed !== out_tdata || e.st !== out_tuser) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp %h st %0d, got %h st %0d",
                     ed, e.st, out_tdata, out_tuser);
        end
      end
    end
    // ready low for a random run, mostly short, sometimes long
    if (out_hold > 0) begin
      out_hold--;
      out_tready <= 1'b0;
    end else begin
      out_hold = gap_len();
      out_tready <= (out_hold == 0);
    end
  end

  initial begin
    #2000000;
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    res_word_t none;
    none = mkr(0, 0, 0, 0, ST_OK);
    add_row(mk(OP_ADD, ONE, 2*ONE, 3*ONE, 4*ONE, ONE, ONE, ONE, ONE, 0), 1,
            mkr(2*ONE, 3*ONE, 4*ONE, 5*ONE, ST_OK));
    add_row(mk(OP_ADD, QMAX, QMIN, QMAX, 0, 1, -1, 0, 0, 0), 1,
            mkr(QMAX, QMIN, QMAX, 0, ST_SAT));
    add_row(mk(OP_SUB, QMIN, QMAX, 0, 5, 1, -1, 0, 5, 0), 1,
            mkr(QMIN, QMAX, 0, 0, ST_SAT));
    add_row(mk(OP_MUL, ONE, 0, 0, 0, 0, ONE, 0, 0, 0), 1,
            mkr(0, ONE, 0, 0, ST_OK));
    add_row(mk(OP_MUL, 0, ONE, 0, 0, 0, ONE, 0, 0, 0), 1,
            mkr(-ONE, 0, 0, 0, ST_OK));
    add_row(mk(OP_MUL, QMAX, QMAX, QMIN, QMIN, QMAX, QMIN, QMAX, QMIN, 0), 0, none);
    add_row(mk(OP_MUL, -1, -1, -1, -1, 1, 1, 1, 1, 0), 0, none);
    add_row(mk(OP_SCL, ONE, -ONE, 3, QMAX, 0, 0, 0, 0, 2*ONE), 1,
            mkr(2*ONE, -2*ONE, 6, QMAX, ST_SAT));
    add_row(mk(OP_SCL, -1, 1, QMIN, 0, 0, 0, 0, 0, ONE/2), 0, none);
    add_row(mk(OP_DIV, ONE, 2, 3, 4, 0, 0, 0, 0, 0), 1,
            mkr(0, 0, 0, 0, ST_DZ));
    add_row(mk(OP_DIV, ONE, -ONE, 7, -7, 0, 0, 0, 0, 2*ONE), 0, none);
    add_row(mk(OP_DIV, QMIN, QMAX, 1, 0, 0, 0, 0, 0, 1), 0, none);
    add_row(mk(OP_DIV, QMIN, 0, 0, 0, 0, 0, 0, 0, -ONE), 1,
            mkr(QMAX, 0, 0, 0, ST_SAT));
    add_row(mk(OP_CNJ, ONE, 2, -3, QMIN, 0, 0, 0, 0, 0), 1,
            mkr(ONE, -2, 3, QMAX, ST_SAT));
    add_row(mk(OP_CNJ, QMIN, QMAX, 0, 1, 0, 0, 0, 0, 0), 1,
            mkr(QMIN, -QMAX, 0, -1, ST_OK));
    add_row(mk(OP_INV, 0, 0, 0, 0, ONE, ONE, 0, 0, ONE), 1,
            mkr(0, 0, 0, 0, ST_DZ));
    add_row(mk(OP_INV, 2*ONE, 0, 0, 0, 0, 0, 0, 0, 0), 1,
            mkr(ONE/2, 0, 0, 0, ST_OK));
    add_row(mk(OP_INV, 1, 0, 0, 0, 0, 0, 0, 0, 0), 1,
            mkr(QMAX, 0, 0, 0, ST_SAT));
    add_row(mk(OP_INV, QMIN, QMAX, QMIN, QMAX, 0, 0, 0, 0, 0), 0, none);
    add_row(mk(OP_INV, ONE, ONE, -ONE, 3, 0, 0, 0, 0, 0), 0, none);
    add_row(mk(OP_NOP, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE), 1, none);
    add_row(mk(OP_ADD, -1, -1, -1, -1, -1, -1, -1, -1, -1), 0, none);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tbl[i]) send_word(dir_tbl[i], dir_has_exp[i], dir_exp[i]);
    for (int n = 0; n < NRAND; n++) begin
      // hold off once mid-run until the pipeline drains
      if (n == NRAND / 2) begin
        in_tvalid <= 1'b0;
        while (quat_expq.size() != 0) @(posedge clk);
      end
      send_word(rnd_word(), 0, none);
    end
    in_tvalid <= 1'b0;
    while (quat_expq.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end
endmodule
